// ===== src/rvx_pkg.sv =====
// rvx_pkg: shared types, codes and helpers for the rv32im decode/execute block
// no dependencies
package rvx_pkg;

  localparam int NUM_REGS = 32;
  localparam int QDEPTH   = 2;

  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_LOAD  = 3'd1;
  localparam logic [2:0] ST_ECALL = 3'd2;
  localparam logic [2:0] ST_EBRK  = 3'd3;
  localparam logic [2:0] ST_BAD   = 3'd4;
  localparam logic [2:0] ST_PROTO = 3'd5;

  localparam logic [1:0] MEM_NONE  = 2'd0;
  localparam logic [1:0] MEM_READ  = 2'd1;
  localparam logic [1:0] MEM_WRITE = 2'd2;

  localparam logic [6:0] OP_LUI    = 7'h37;
  localparam logic [6:0] OP_AUIPC  = 7'h17;
  localparam logic [6:0] OP_JAL    = 7'h6f;
  localparam logic [6:0] OP_JALR   = 7'h67;
  localparam logic [6:0] OP_BRANCH = 7'h63;
  localparam logic [6:0] OP_LOAD   = 7'h03;
  localparam logic [6:0] OP_STORE  = 7'h23;
  localparam logic [6:0] OP_IMM    = 7'h13;
  localparam logic [6:0] OP_REG    = 7'h33;
  localparam logic [6:0] OP_SYSTEM = 7'h73;

  localparam logic [31:0] ECALL_WORD  = 32'h0000_0073;
  localparam logic [31:0] EBREAK_WORD = 32'h0010_0073;
  localparam logic [4:0]  REG_A0      = 5'd10;
  localparam logic [6:0]  F7_MULDIV   = 7'h01;
  localparam logic [6:0]  F7_ALT      = 7'h20;

  typedef struct packed {
    logic        req_type;
    logic [31:0] instr_word;
    logic [31:0] instr_pc;
    logic [31:0] load_data;
  } in_item_t;

  typedef struct packed {
    logic [31:0] next_pc;
    logic [1:0]  mem_op;
    logic [31:0] mem_addr;
    logic [1:0]  mem_size;
    logic [31:0] mem_wdata;
    logic        wb_valid;
    logic [4:0]  wb_reg;
    logic [31:0] wb_data;
    logic [2:0]  status;
    logic [31:0] trap_value;
  } out_item_t;

  typedef enum logic [1:0] {CLS_DATA, CLS_BASE, CLS_MUL, CLS_DIV} cls_t;

  typedef struct packed {
    cls_t     cls;
    in_item_t item;
  } q_entry_t;

  typedef enum logic [1:0] {S_IDLE, S_EXEC, S_MUL, S_DIV} state_t;

  typedef struct packed {
    logic        done;
    logic [31:0] quo;
    logic [31:0] rem;
  } div_res_t;

  function automatic logic reg_ok(logic [4:0] r);
    return (r != 5'd0) && ({1'b0, r} < 6'(NUM_REGS));
  endfunction

endpackage

// ===== src/rvx_front.sv =====
// rvx_front: input side, classifies each beat and holds it in a short queue
// depends on rvx_pkg
module rvx_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  output logic              in_full,
  input  rvx_pkg::in_item_t in_item,
  input  logic              q_pop,
  output logic              q_empty,
  output rvx_pkg::q_entry_t q_head
);
  rvx_pkg::q_entry_t ent_r [rvx_pkg::QDEPTH];
  logic [$clog2(rvx_pkg::QDEPTH)-1:0] wp_r, rp_r;
  logic [$clog2(rvx_pkg::QDEPTH+1)-1:0] cnt_r;
  rvx_pkg::cls_t cls;
  logic push_ok, pop_ok;

  // muldiv (all but mulhsu) split off so the back end can take its multi-cycle path
  always_comb begin
    cls = rvx_pkg::CLS_BASE;
    if (in_item.req_type) begin
      cls = rvx_pkg::CLS_DATA;
    end else if (in_item.instr_word[6:0] == rvx_pkg::OP_REG &&
                 in_item.instr_word[31:25] == rvx_pkg::F7_MULDIV) begin
      if (in_item.instr_word[14]) cls = rvx_pkg::CLS_DIV;
      else if (in_item.instr_word[14:12] != 3'd2) cls = rvx_pkg::CLS_MUL;
    end
  end

  assign in_full = (cnt_r == ($clog2(rvx_pkg::QDEPTH+1))'(rvx_pkg::QDEPTH));
  assign q_empty = (cnt_r == '0);
  assign push_ok = in_push && !in_full;
  assign pop_ok  = q_pop && !q_empty;
  assign q_head  = ent_r[rp_r];

  always_ff @(posedge clk) begin
    if (push_ok) begin
      ent_r[wp_r] <= '{cls: cls, item: in_item};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push_ok) wp_r <= wp_r + 1'b1;
      if (pop_ok) rp_r <= rp_r + 1'b1;
      if (push_ok && !pop_ok) cnt_r <= cnt_r + 1'b1;
      else if (pop_ok && !push_ok) cnt_r <= cnt_r - 1'b1;
    end
  end
endmodule

// ===== src/rvx_div.sv =====
// rvx_div: unsigned restoring divider, one quotient bit per cycle
// depends on rvx_pkg
module rvx_div (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [31:0]        dividend,
  input  logic [31:0]        divisor,
  output rvx_pkg::div_res_t  res
);
  logic [31:0] quo_r, dvs_r;
  logic [32:0] rem_r;
  logic [4:0]  cnt_r;
  logic        busy_r, done_r;
  logic [32:0] shifted, diff;

  assign shifted = {rem_r[31:0], quo_r[31]};
  assign diff    = shifted - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      dvs_r <= divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      if (!diff[32]) begin
        rem_r <= diff;
        quo_r <= {quo_r[30:0], 1'b1};
      end else begin
        rem_r <= shifted;
        quo_r <= {quo_r[30:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == 5'd31) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign res = '{done: done_r, quo: quo_r, rem: rem_r[31:0]};
endmodule

// ===== src/rvx_back.sv =====
// rvx_back: execute side, register file, load tracking, muldiv and result register
// depends on rvx_pkg, rvx_div
module rvx_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_empty,
  input  rvx_pkg::q_entry_t  q_head,
  output logic               q_pop,
  output logic               out_empty,
  input  logic               out_pop,
  output rvx_pkg::out_item_t out_item
);
  rvx_pkg::state_t state_r, state_nxt;
  rvx_pkg::q_entry_t ent_r;
  logic [31:0] rf_mem [32];
  logic [31:0] rf_vld_r;
  logic [31:0] rda_r, rdb_r;
  logic        va_r, vb_r;
  logic [4:0]  addr_a, addr_b;
  logic [31:0] a, b;
  logic        lp_r, psg_r;
  logic [4:0]  pd_r;
  logic [1:0]  ps_r;
  logic [63:0] prod_r;
  rvx_pkg::out_item_t out_r, fin_o, ex_o;
  logic        out_v_r;
  logic        fin, div_start, ex_ld, ex_ldclr, rf_we, ex_we, dec_we;
  logic [4:0]  rf_waddr, ex_wreg;
  logic [31:0] rf_wdata, ex_wdata;
  rvx_pkg::div_res_t dres;
  logic [31:0] w, pc, immI, immS, immB, immJ, immU, res, lv, mres, dres_v, hi;
  logic [6:0]  opc, f7;
  logic [2:0]  f3;
  logic [4:0]  rd;
  logic        bad, tk, dsgn, dneg_q;

  assign addr_a = q_head.item.instr_word[19:15];
  assign addr_b = (q_head.item.instr_word == rvx_pkg::EBREAK_WORD) ? rvx_pkg::REG_A0
                                                                  : q_head.item.instr_word[24:20];
  assign a = va_r ? rda_r : 32'd0;
  assign b = vb_r ? rdb_r : 32'd0;

  always_ff @(posedge clk) begin
    if (q_pop) begin
      ent_r <= q_head;
      rda_r <= rf_mem[addr_a];
      rdb_r <= rf_mem[addr_b];
    end
    if (rf_we) rf_mem[rf_waddr] <= rf_wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rf_vld_r <= '0;
      va_r     <= 1'b0;
      vb_r     <= 1'b0;
    end else begin
      if (q_pop) begin
        va_r <= rf_vld_r[addr_a] && rvx_pkg::reg_ok(addr_a);
        vb_r <= rf_vld_r[addr_b] && rvx_pkg::reg_ok(addr_b);
      end
      if (rf_we) rf_vld_r[rf_waddr] <= 1'b1;
    end
  end

  assign w   = ent_r.item.instr_word;
  assign pc  = ent_r.item.instr_pc;
  assign opc = w[6:0];
  assign rd  = w[11:7];
  assign f3  = w[14:12];
  assign f7  = w[31:25];
  assign immI = {{20{w[31]}}, w[31:20]};
  assign immS = {{20{w[31]}}, w[31:25], w[11:7]};
  assign immB = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
  assign immJ = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
  assign immU = {w[31:12], 12'd0};

  always_comb begin
    case (ps_r)
      2'd0:    lv = {{24{psg_r & ent_r.item.load_data[7]}}, ent_r.item.load_data[7:0]};
      2'd1:    lv = {{16{psg_r & ent_r.item.load_data[15]}}, ent_r.item.load_data[15:0]};
      default: lv = ent_r.item.load_data;
    endcase
  end

  // combinational decode and execute of everything but mul and div
  always_comb begin
    ex_o     = '0;
    ex_we    = 1'b0;
    ex_wreg  = rd;
    ex_wdata = '0;
    ex_ld    = 1'b0;
    ex_ldclr = 1'b0;
    dec_we   = 1'b0;
    res      = '0;
    bad      = 1'b0;
    tk       = 1'b0;
    if (ent_r.item.req_type) begin
      if (!lp_r) begin
        ex_o.status = rvx_pkg::ST_PROTO;
      end else begin
        ex_ldclr = 1'b1;
        ex_wreg  = pd_r;
        ex_wdata = lv;
        ex_we    = rvx_pkg::reg_ok(pd_r);
      end
    end else if (lp_r) begin
      ex_o.next_pc = pc;
      ex_o.status  = rvx_pkg::ST_PROTO;
    end else begin
      ex_o.next_pc = pc + 32'd4;
      case (opc)
        rvx_pkg::OP_LUI: begin
          res = immU; dec_we = 1'b1;
        end
        rvx_pkg::OP_AUIPC: begin
          res = pc + immU; dec_we = 1'b1;
        end
        rvx_pkg::OP_JAL: begin
          res = pc + 32'd4; dec_we = 1'b1; ex_o.next_pc = pc + immJ;
        end
        rvx_pkg::OP_JALR: begin
          if (f3 != 3'd0) bad = 1'b1;
          res = pc + 32'd4; dec_we = 1'b1;
          ex_o.next_pc = (a + immI) & ~32'd1;
        end
        rvx_pkg::OP_BRANCH: begin
          case (f3)
            3'd0:    tk = (a == b);
            3'd1:    tk = (a != b);
            3'd4:    tk = ($signed(a) < $signed(b));
            3'd5:    tk = !($signed(a) < $signed(b));
            3'd6:    tk = (a < b);
            3'd7:    tk = (a >= b);
            default: bad = 1'b1;
          endcase
          if (tk) ex_o.next_pc = pc + immB;
        end
        rvx_pkg::OP_LOAD: begin
          if (f3 == 3'd3 || f3 > 3'd5) begin
            bad = 1'b1;
          end else begin
            ex_o.mem_op   = rvx_pkg::MEM_READ;
            ex_o.mem_addr = a + immI;
            ex_o.mem_size = f3[1:0];
            ex_o.status   = rvx_pkg::ST_LOAD;
            ex_ld         = 1'b1;
          end
        end
        rvx_pkg::OP_STORE: begin
          if (f3 > 3'd2) begin
            bad = 1'b1;
          end else begin
            ex_o.mem_op    = rvx_pkg::MEM_WRITE;
            ex_o.mem_addr  = a + immS;
            ex_o.mem_size  = f3[1:0];
            ex_o.mem_wdata = b;
          end
        end
        rvx_pkg::OP_IMM: begin
          dec_we = 1'b1;
          case (f3)
            3'd0: res = a + immI;
            3'd2: res = {31'd0, $signed(a) < $signed(immI)};
            3'd3: res = {31'd0, a < immI};
            3'd4: res = a ^ immI;
            3'd6: res = a | immI;
            3'd7: res = a & immI;
            3'd1: begin
              if (f7 != 7'd0) bad = 1'b1;
              res = a << w[24:20];
            end
            default: begin
              if (f7 == 7'd0) res = a >> w[24:20];
              else if (f7 == rvx_pkg::F7_ALT) res = 32'($signed(a) >>> w[24:20]);
              else bad = 1'b1;
            end
          endcase
        end
        rvx_pkg::OP_REG: begin
          dec_we = 1'b1;
          if (f7 == 7'd0) begin
            case (f3)
              3'd0:    res = a + b;
              3'd1:    res = a << b[4:0];
              3'd2:    res = {31'd0, $signed(a) < $signed(b)};
              3'd3:    res = {31'd0, a < b};
              3'd4:    res = a ^ b;
              3'd5:    res = a >> b[4:0];
              3'd6:    res = a | b;
              default: res = a & b;
            endcase
          end else if (f7 == rvx_pkg::F7_ALT && f3 == 3'd0) begin
            res = a - b;
          end else if (f7 == rvx_pkg::F7_ALT && f3 == 3'd5) begin
            res = 32'($signed(a) >>> b[4:0]);
          end else begin
            // mulhsu, unknown encodings and mul/div land here; for mul/div this result goes unused
            bad = 1'b1;
          end
        end
        rvx_pkg::OP_SYSTEM: begin
          if (w == rvx_pkg::ECALL_WORD) begin
            ex_o.status = rvx_pkg::ST_ECALL; ex_o.next_pc = pc;
          end else if (w == rvx_pkg::EBREAK_WORD) begin
            ex_o.status = rvx_pkg::ST_EBRK; ex_o.next_pc = pc;
            ex_o.trap_value = b;
          end else begin
            bad = 1'b1;
          end
        end
        default: bad = 1'b1;
      endcase
      if (bad) begin
        ex_o         = '0;
        ex_o.next_pc = pc;
        ex_o.status  = rvx_pkg::ST_BAD;
        ex_ld        = 1'b0;
      end else begin
        ex_we    = dec_we && rvx_pkg::reg_ok(rd);
        ex_wdata = res;
      end
    end
    if (ex_we) begin
      ex_o.wb_valid = 1'b1;
      ex_o.wb_reg   = ex_wreg;
      ex_o.wb_data  = ex_wdata;
    end
  end

  // multiply high-part fix-up on the registered product
  always_comb begin
    hi = prod_r[63:32];
    case (f3)
      3'd0:    mres = prod_r[31:0];
      3'd1:    mres = hi - (a[31] ? b : 32'd0) - (b[31] ? a : 32'd0);
      default: mres = hi;
    endcase
  end

  assign dsgn   = !f3[0];
  assign dneg_q = dsgn && (a[31] ^ b[31]);
  always_comb begin
    if (b == 32'd0) begin
      dres_v = f3[1] ? a : 32'hffff_ffff;
    end else if (!f3[1]) begin
      dres_v = dneg_q ? (32'd0 - dres.quo) : dres.quo;
    end else begin
      dres_v = (dsgn && a[31]) ? (32'd0 - dres.rem) : dres.rem;
    end
  end

  rvx_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend ((dsgn && a[31]) ? (32'd0 - a) : a),
    .divisor  ((dsgn && b[31]) ? (32'd0 - b) : b),
    .res      (dres)
  );

  always_comb begin
    state_nxt = state_r;
    q_pop     = 1'b0;
    div_start = 1'b0;
    fin       = 1'b0;
    fin_o     = ex_o;
    rf_we     = 1'b0;
    rf_waddr  = ex_wreg;
    rf_wdata  = ex_wdata;
    case (state_r)
      rvx_pkg::S_IDLE: begin
        if (!q_empty && !out_v_r) begin
          q_pop     = 1'b1;
          state_nxt = rvx_pkg::S_EXEC;
        end
      end
      rvx_pkg::S_EXEC: begin
        if (!lp_r && ent_r.cls == rvx_pkg::CLS_MUL) begin
          state_nxt = rvx_pkg::S_MUL;
        end else if (!lp_r && ent_r.cls == rvx_pkg::CLS_DIV) begin
          div_start = 1'b1;
          state_nxt = rvx_pkg::S_DIV;
        end else begin
          fin       = 1'b1;
          rf_we     = ex_we;
          state_nxt = rvx_pkg::S_IDLE;
        end
      end
      rvx_pkg::S_MUL, rvx_pkg::S_DIV: begin
        if (state_r == rvx_pkg::S_MUL || dres.done) begin
          fin           = 1'b1;
          fin_o         = '0;
          fin_o.next_pc = pc + 32'd4;
          rf_waddr      = rd;
          rf_wdata      = (state_r == rvx_pkg::S_MUL) ? mres : dres_v;
          rf_we         = rvx_pkg::reg_ok(rd);
          if (rf_we) begin
            fin_o.wb_valid = 1'b1;
            fin_o.wb_reg   = rd;
            fin_o.wb_data  = rf_wdata;
          end
          state_nxt = rvx_pkg::S_IDLE;
        end
      end
      default: state_nxt = rvx_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state_r == rvx_pkg::S_EXEC) prod_r <= a * b;
    if (fin) out_r <= fin_o;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rvx_pkg::S_IDLE;
      out_v_r <= 1'b0;
      lp_r    <= 1'b0;
      pd_r    <= '0;
      ps_r    <= '0;
      psg_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (fin) out_v_r <= 1'b1;
      else if (out_pop) out_v_r <= 1'b0;
      if (state_r == rvx_pkg::S_EXEC) begin
        if (ex_ld) begin
          lp_r  <= 1'b1;
          pd_r  <= rd;
          ps_r  <= f3[1:0];
          psg_r <= !f3[2];
        end else if (ex_ldclr) begin
          lp_r <= 1'b0;
        end
      end
    end
  end

  assign out_empty = !out_v_r;
  assign out_item  = out_r;
endmodule

// ===== src/rv32im_decode_execute_top.sv =====
// rv32im decode/execute unit: one beat in, one result beat out
// items pass pop (with register read) and execute; mul/mulh/mulhu add a multiply
// state, div/rem a divide state; the back end sequencer takes one item at a time and
// pops the next only once the result slot is empty; divides hold it for the 32-step divider
// reset: synchronous active-low rst_n empties the queue and result slot, clears load
// tracking and marks every register as zero through per-register valid bits
module rv32im_decode_execute_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  rvx_pkg::in_item_t  in_item,
  output logic               out_empty,
  input  logic               out_pop,
  output rvx_pkg::out_item_t out_item
);
  logic              q_pop, q_empty;
  rvx_pkg::q_entry_t q_head;

  // front end: classifies beats and buffers up to two
  rvx_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_push (in_push),
    .in_full (in_full),
    .in_item (in_item),
    .q_pop   (q_pop),
    .q_empty (q_empty),
    .q_head  (q_head)
  );

  // back end: register file, execute, result register
  rvx_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_item  (out_item)
  );
endmodule

// ===== src/rvx_checker.sv =====
// rvx_checker: port-level assertions on the top level, bound in below
// depends on rvx_pkg, rv32im_decode_execute_top
module rvx_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_full,
  input logic               out_empty,
  input logic               out_pop,
  input rvx_pkg::out_item_t out_item
);
  // a waiting result beat holds until taken
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_item)))
    else $error("result beat changed while waiting");

  a_rst: assert property (@(posedge clk) !rst_n |=> (out_empty && !in_full))
    else $error("queues not empty after reset");

  a_stat: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> (out_item.status <= rvx_pkg::ST_PROTO))
    else $error("bad status code");

  a_nomem: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_item.mem_op == rvx_pkg::MEM_NONE) |->
      (out_item.mem_addr == 32'd0 && out_item.mem_wdata == 32'd0))
    else $error("memory fields set without request");

  a_trap: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_item.status != rvx_pkg::ST_OK) |-> !out_item.wb_valid ||
      out_item.status == rvx_pkg::ST_PROTO)
    else $error("writeback alongside trap or load");
endmodule

bind rv32im_decode_execute_top rvx_checker u_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_full   (in_full),
  .out_empty (out_empty),
  .out_pop   (out_pop),
  .out_item  (out_item)
);

// ===== tb/sv/rv32im_decode_execute_top_test.sv =====
// testbench for rv32im_decode_execute_top: directed table then constrained-by-hand random
// instruction streams, each result checked against an in-bench model of the execute unit
// depends on rvx_pkg and the rv32im_decode_execute_top rtl
`timescale 1ns / 100ps

module rv32im_decode_execute_top_test;

  localparam int CYCLE_LIMIT = 400000;

  logic               clk;
  logic               rst_n;
  logic               in_push;
  logic               in_full;
  rvx_pkg::in_item_t  in_item;
  logic               out_empty;
  logic               out_pop;
  rvx_pkg::out_item_t out_item;

  rv32im_decode_execute_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .in_full(in_full), .in_item(in_item),
    .out_empty(out_empty), .out_pop(out_pop), .out_item(out_item)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // shadow architectural state
  logic [31:0] gpr [32];
  logic        ld_busy;
  logic [4:0]  ld_dest;
  logic [1:0]  ld_size;
  logic        ld_sext;

  rvx_pkg::out_item_t expected_results [$];
  int        error_count;
  int        cycle_count;
  int        idle_pct;      // 0 during the no-idling stretch
  bit        feeding_done;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %h want %h (cycle %0d)", what, got, want, cycle_count);
    error_count++;
  endtask

  function automatic logic [31:0] read_gpr(input logic [4:0] r);
    return rvx_pkg::reg_ok(r) ? gpr[r] : 32'd0;
  endfunction

  function automatic logic signed_lt(input logic [31:0] a, input logic [31:0] b);
    return $signed(a) < $signed(b);
  endfunction

  // work out the result beat for one accepted item and update the shadow state
  function automatic rvx_pkg::out_item_t execute_item(input rvx_pkg::in_item_t it);
    rvx_pkg::out_item_t o;
    logic [31:0] w, pc, a, b, res, imm_i, imm_s, imm_b, imm_j, imm_u, v;
    logic [6:0]  opc, f7;
    logic [4:0]  rd;
    logic [2:0]  f3;
    logic [63:0] prod;
    logic        wr, bad, taken;
    o = '0;
    w = it.instr_word;
    pc = it.instr_pc;
    res = '0;
    wr = 1'b0;
    bad = 1'b0;
    taken = 1'b0;
    if (it.req_type) begin
      if (!ld_busy) begin
        o.status = rvx_pkg::ST_PROTO;
      end else begin
        v = it.load_data;
        case (ld_size)
          2'd0: v = ld_sext ? {{24{v[7]}}, v[7:0]} : {24'd0, v[7:0]};
          2'd1: v = ld_sext ? {{16{v[15]}}, v[15:0]} : {16'd0, v[15:0]};
          default: ;
        endcase
        if (rvx_pkg::reg_ok(ld_dest)) begin
          gpr[ld_dest] = v;
          o.wb_valid = 1'b1; o.wb_reg = ld_dest; o.wb_data = v;
        end
        ld_busy = 1'b0;
      end
      return o;
    end
    if (ld_busy) begin
      o.next_pc = pc; o.status = rvx_pkg::ST_PROTO;
      return o;
    end
    opc = w[6:0]; rd = w[11:7]; f3 = w[14:12]; f7 = w[31:25];
    a = read_gpr(w[19:15]); b = read_gpr(w[24:20]);
    imm_i = {{20{w[31]}}, w[31:20]};
    imm_s = {{20{w[31]}}, w[31:25], w[11:7]};
    imm_b = {{20{w[31]}}, w[7], w[30:25], w[11:8], 1'b0};
    imm_j = {{12{w[31]}}, w[19:12], w[20], w[30:21], 1'b0};
    imm_u = {w[31:12], 12'd0};
    o.next_pc = pc + 32'd4;
    case (opc)
      rvx_pkg::OP_LUI:   begin res = imm_u; wr = 1'b1; end
      rvx_pkg::OP_AUIPC: begin res = pc + imm_u; wr = 1'b1; end
      rvx_pkg::OP_JAL:   begin res = pc + 32'd4; wr = 1'b1; o.next_pc = pc + imm_j; end
      rvx_pkg::OP_JALR: begin
        if (f3 != 3'd0) bad = 1'b1;
        else begin
          res = pc + 32'd4; wr = 1'b1; o.next_pc = (a + imm_i) & ~32'd1;
        end
      end
      rvx_pkg::OP_BRANCH: begin
        case (f3)
          3'd0: taken = a == b;
          3'd1: taken = a != b;
          3'd4: taken = signed_lt(a, b);
          3'd5: taken = !signed_lt(a, b);
          3'd6: taken = a < b;
          3'd7: taken = a >= b;
          default: bad = 1'b1;
        endcase
        if (taken) o.next_pc = pc + imm_b;
      end
      rvx_pkg::OP_LOAD: begin
        if (f3 == 3'd3 || f3 > 3'd5) bad = 1'b1;
        else begin
          o.mem_op = rvx_pkg::MEM_READ; o.mem_addr = a + imm_i; o.mem_size = f3[1:0];
          o.status = rvx_pkg::ST_LOAD;
          ld_busy = 1'b1; ld_dest = rd; ld_size = f3[1:0]; ld_sext = !f3[2];
        end
      end
      rvx_pkg::OP_STORE: begin
        if (f3 > 3'd2) bad = 1'b1;
        else begin
          o.mem_op = rvx_pkg::MEM_WRITE; o.mem_addr = a + imm_s; o.mem_size = f3[1:0];
          o.mem_wdata = b;
        end
      end
      rvx_pkg::OP_IMM: begin
        wr = 1'b1;
        case (f3)
          3'd0: res = a + imm_i;
          3'd2: res = {31'd0, signed_lt(a, imm_i)};
          3'd3: res = {31'd0, a < imm_i};
          3'd4: res = a ^ imm_i;
          3'd6: res = a | imm_i;
          3'd7: res = a & imm_i;
          3'd1: if (f7 != 7'd0) bad = 1'b1; else res = a << w[24:20];
          default: begin
            if (f7 == 7'd0) res = a >> w[24:20];
            else if (f7 == rvx_pkg::F7_ALT) res = $signed(a) >>> w[24:20];
            else bad = 1'b1;
          end
        endcase
      end
      rvx_pkg::OP_REG: begin
        wr = 1'b1;
        if (f7 == 7'd0) begin
          case (f3)
            3'd0: res = a + b;
            3'd1: res = a << b[4:0];
            3'd2: res = {31'd0, signed_lt(a, b)};
            3'd3: res = {31'd0, a < b};
            3'd4: res = a ^ b;
            3'd5: res = a >> b[4:0];
            3'd6: res = a | b;
            default: res = a & b;
          endcase
        end else if (f7 == rvx_pkg::F7_ALT && f3 == 3'd0) res = a - b;
        else if (f7 == rvx_pkg::F7_ALT && f3 == 3'd5) res = $signed(a) >>> b[4:0];
        else if (f7 == rvx_pkg::F7_MULDIV) begin
          case (f3)
            3'd0: res = a * b;
            3'd1: begin
              prod = $signed({{32{a[31]}}, a}) * $signed({{32{b[31]}}, b});
              res = prod[63:32];
            end
            3'd3: begin prod = {32'd0, a} * {32'd0, b}; res = prod[63:32]; end
            3'd4: begin
              if (b == 0) res = '1;
              else if (a == 32'h8000_0000 && b == '1) res = a;
              else res = $signed(a) / $signed(b);
            end
            3'd5: res = (b == 0) ? '1 : a / b;
            3'd6: begin
              if (b == 0) res = a;
              else if (a == 32'h8000_0000 && b == '1) res = '0;
              else res = $signed(a) % $signed(b);
            end
            3'd7: res = (b == 0) ? a : a % b;
            default: bad = 1'b1;
          endcase
        end else bad = 1'b1;
      end
      rvx_pkg::OP_SYSTEM: begin
        if (w == rvx_pkg::ECALL_WORD) begin
          o.status = rvx_pkg::ST_ECALL; o.next_pc = pc;
        end else if (w == rvx_pkg::EBREAK_WORD) begin
          o.status = rvx_pkg::ST_EBRK; o.next_pc = pc;
          o.trap_value = read_gpr(rvx_pkg::REG_A0);
        end else bad = 1'b1;
      end
      default: bad = 1'b1;
    endcase
    if (bad) begin
      o = '0; o.next_pc = pc; o.status = rvx_pkg::ST_BAD;
    end else if (wr && rvx_pkg::reg_ok(rd)) begin
      gpr[rd] = res;
      o.wb_valid = 1'b1; o.wb_reg = rd; o.wb_data = res;
    end
    return o;
  endfunction

  // ---------------------------------------------------------------- sender side
  // one beat offered from the falling edge until accepted
  task automatic send_beat(input rvx_pkg::in_item_t it);
    while (idle_pct != 0 && $urandom_range(99, 0) < idle_pct) begin
      in_push <= 1'b0;
      @(negedge clk);
    end
    in_item <= it;
    in_push <= 1'b1;
    @(posedge clk);
    while (in_full) @(posedge clk);
    expected_results.push_back(execute_item(it));
    @(negedge clk);
  endtask

  function automatic rvx_pkg::in_item_t instr(input logic [31:0] w, input logic [31:0] pc);
    rvx_pkg::in_item_t it;
    it = '0;
    it.instr_word = w; it.instr_pc = pc; it.load_data = $urandom();
    return it;
  endfunction

  function automatic rvx_pkg::in_item_t data_beat(input logic [31:0] d);
    rvx_pkg::in_item_t it;
    it = '0;
    it.req_type = 1'b1; it.load_data = d; it.instr_word = $urandom();
    it.instr_pc = $urandom();
    return it;
  endfunction

  // encoders for well-formed words
  function automatic logic [31:0] enc_r(input logic [6:0] f7, input logic [4:0] rs2,
      input logic [4:0] rs1, input logic [2:0] f3, input logic [4:0] rd);
    return {f7, rs2, rs1, f3, rd, rvx_pkg::OP_REG};
  endfunction

  function automatic logic [31:0] enc_i(input logic [11:0] imm, input logic [4:0] rs1,
      input logic [2:0] f3, input logic [4:0] rd, input logic [6:0] opc);
    return {imm, rs1, f3, rd, opc};
  endfunction

  // random instruction, mostly well-formed, registers drawn mostly from a small pool
  function automatic logic [31:0] random_instr();
    logic [4:0]  rd, rs1, rs2;
    logic [2:0]  f3;
    logic [11:0] imm;
    int          pick;
    rd = $urandom_range(7, 0) == 0 ? 5'($urandom()) : 5'($urandom_range(12, 0));
    rs1 = $urandom_range(7, 0) == 0 ? 5'($urandom()) : 5'($urandom_range(12, 0));
    rs2 = $urandom_range(7, 0) == 0 ? 5'($urandom()) : 5'($urandom_range(12, 0));
    f3 = 3'($urandom());
    imm = 12'($urandom());
    pick = $urandom_range(99, 0);
    if (pick < 8) return {20'($urandom()), rd, rvx_pkg::OP_LUI};
    if (pick < 12) return {20'($urandom()), rd, rvx_pkg::OP_AUIPC};
    if (pick < 15) return {20'($urandom()), rd, rvx_pkg::OP_JAL};
    if (pick < 18) return enc_i(imm, rs1, 3'd0, rd, rvx_pkg::OP_JALR);
    if (pick < 26) return {imm[11:5], rs2, rs1, f3, imm[4:0], rvx_pkg::OP_BRANCH};
    if (pick < 38) return enc_i(imm, rs1, f3, rd, rvx_pkg::OP_LOAD);
    if (pick < 44) return {imm[11:5], rs2, rs1, f3, imm[4:0], rvx_pkg::OP_STORE};
    if (pick < 62) begin
      if (f3 == 3'd1 || f3 == 3'd5)
        imm[11:5] = ($urandom_range(9, 0) == 0) ? 7'($urandom())
                    : ((f3 == 3'd5 && $urandom_range(1, 0)) ? rvx_pkg::F7_ALT : 7'd0);
      return enc_i(imm, rs1, f3, rd, rvx_pkg::OP_IMM);
    end
    if (pick < 74)
      return enc_r($urandom_range(1, 0) ? rvx_pkg::F7_ALT : 7'd0, rs2, rs1, f3, rd);
    if (pick < 90) return enc_r(rvx_pkg::F7_MULDIV, rs2, rs1, f3, rd);
    if (pick < 92) return rvx_pkg::ECALL_WORD;
    if (pick < 94) return rvx_pkg::EBREAK_WORD;
    return $urandom();  // noise, mostly invalid
  endfunction

  // data operand values that hit the edges often
  function automatic logic [31:0] edge_value();
    case ($urandom_range(7, 0))
      0: return 32'd0;
      1: return 32'hffff_ffff;
      2: return 32'h8000_0000;
      3: return 32'h7fff_ffff;
      4: return 32'($urandom_range(8, 0));
      default: return $urandom();
    endcase
  endfunction

  typedef struct {
    rvx_pkg::in_item_t  item;
    bit                 has_golden;
    rvx_pkg::out_item_t golden;
  } stim_row_t;

  stim_row_t stim_table [$];

  task automatic add_row(input rvx_pkg::in_item_t it);
    stim_row_t r;
    r.item = it; r.has_golden = 1'b0; r.golden = '0;
    stim_table.push_back(r);
  endtask

  task automatic add_golden(input rvx_pkg::in_item_t it, input rvx_pkg::out_item_t g);
    stim_row_t r;
    r.item = it; r.has_golden = 1'b1; r.golden = g;
    stim_table.push_back(r);
  endtask

  function automatic rvx_pkg::out_item_t status_only(input logic [31:0] npc,
                                                     input logic [2:0] st);
    rvx_pkg::out_item_t o;
    o = '0; o.next_pc = npc; o.status = st;
    return o;
  endfunction

  // ---------------------------------------------------------------- stimulus
  initial begin : stimulus
    rvx_pkg::out_item_t g;
    logic [31:0] pc;
    logic [31:0] ev;
    int          n;
    in_push = 1'b0;
    in_item = '0;
    rst_n = 1'b0;
    idle_pct = 21;
    feeding_done = 1'b0;
    error_count = 0;
    for (int i = 0; i < 32; i++) gpr[i] = '0;
    ld_busy = 1'b0; ld_dest = '0; ld_size = '0; ld_sext = 1'b0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    // directed table: fixed results where obvious, others from the model
    add_golden(data_beat(32'hffff_ffff), status_only(32'd0, rvx_pkg::ST_PROTO));
    add_golden(instr(rvx_pkg::ECALL_WORD, 32'hffff_fffc),
               status_only(32'hffff_fffc, rvx_pkg::ST_ECALL));
    add_golden(instr(rvx_pkg::EBREAK_WORD, 32'd0), status_only(32'd0, rvx_pkg::ST_EBRK));
    add_golden(instr(32'h0000_100f, 32'h40), status_only(32'h40, rvx_pkg::ST_BAD)); // fence.i
    add_golden(instr(32'h3050_9073, 32'h44), status_only(32'h44, rvx_pkg::ST_BAD)); // csrrw
    add_golden(instr(enc_r(rvx_pkg::F7_MULDIV, 5'd2, 5'd1, 3'd2, 5'd3), 32'h48),
               status_only(32'h48, rvx_pkg::ST_BAD));                               // mulhsu
    add_golden(instr(32'hffff_ffff, 32'h4c), status_only(32'h4c, rvx_pkg::ST_BAD));
    add_row(instr(enc_i(12'h800, 5'd0, 3'd0, 5'd1, rvx_pkg::OP_IMM), 32'h50));  // x1 = -2048
    add_row(instr({20'h80000, 5'd2, rvx_pkg::OP_LUI}, 32'h54));                 // x2 = min
    add_row(instr(enc_i(12'hfff, 5'd0, 3'd0, 5'd3, rvx_pkg::OP_IMM), 32'h58));  // x3 = -1
    add_row(instr(enc_r(rvx_pkg::F7_MULDIV, 5'd3, 5'd2, 3'd4, 5'd4), 32'h5c));  // div ovf
    add_row(instr(enc_r(rvx_pkg::F7_MULDIV, 5'd3, 5'd2, 3'd6, 5'd5), 32'h60));  // rem ovf
    add_row(instr(enc_r(rvx_pkg::F7_MULDIV, 5'd0, 5'd1, 3'd4, 5'd6), 32'h64));  // div by 0
    add_row(instr(enc_r(rvx_pkg::F7_MULDIV, 5'd0, 5'd1, 3'd5, 5'd6), 32'h68));
    add_row(instr(enc_r(rvx_pkg::F7_MULDIV, 5'd0, 5'd1, 3'd6, 5'd6), 32'h6c));
    add_row(instr(enc_r(rvx_pkg::F7_MULDIV, 5'd0, 5'd1, 3'd7, 5'd6), 32'h70));
    add_row(instr(enc_r(rvx_pkg::F7_MULDIV, 5'd3, 5'd2, 3'd1, 5'd7), 32'h74));  // mulh
    add_row(instr(enc_i(12'h7ff, 5'd1, 3'd4, 5'd0, rvx_pkg::OP_LOAD), 32'h78)); // lbu to x0
    add_row(instr(rvx_pkg::ECALL_WORD, 32'h7c));                                // protocol error
    add_row(data_beat(32'h0000_00ff));
    add_row(instr(enc_i(12'h000, 5'd2, 3'd1, 5'd10, rvx_pkg::OP_LOAD), 32'h80)); // lh to a0
    add_row(data_beat(32'h1234_8001));
    add_row(instr(rvx_pkg::EBREAK_WORD, 32'h84));                               // a0 in trap value
    add_row(instr({7'h7f, 5'd3, 5'd2, 3'd2, 5'h1f, rvx_pkg::OP_STORE}, 32'h88));
    add_row(instr({1'b1, 10'h3ff, 1'b1, 8'hff, 5'd9, rvx_pkg::OP_JAL}, 32'h8c));

    foreach (stim_table[i]) begin
      send_beat(stim_table[i].item);
      if (stim_table[i].has_golden) begin
        g = stim_table[i].golden;
        if (expected_results[$] !== g) report_mismatch("table row", i, 0);
      end
    end

    // random part; a stretch without idling, and one pause for a full drain
    pc = $urandom();
    n = 0;
    while (n < 1500) begin
      rvx_pkg::in_item_t it;
      if (n == 300) idle_pct = 0;
      if (n == 600) idle_pct = 21;
      if (n == 750) begin
        in_push <= 1'b0;
        wait (expected_results.size() == 0);
        @(negedge clk);
      end
      if (ld_busy && $urandom_range(19, 0) != 0) it = data_beat(edge_value());
      else if ($urandom_range(29, 0) == 0) it = data_beat($urandom());
      else if (n % 50 == 0) begin
        // seed a register with an edge value through lui
        ev = edge_value();
        it = instr({ev[31:12], 5'($urandom_range(12, 1)), rvx_pkg::OP_LUI}, pc);
      end else it = instr(random_instr(), pc);
      if ($urandom_range(3, 0) == 0) pc = $urandom(); else pc = pc + 32'd4;
      send_beat(it);
      n++;
    end
    in_push <= 1'b0;
    feeding_done = 1'b1;
  end

  // ---------------------------------------------------------------- receiver side
  always @(negedge clk) begin
    if (!rst_n) out_pop <= 1'b0;
    else out_pop <= (idle_pct == 0) || ($urandom_range(99, 0) >= idle_pct);
  end

  always @(posedge clk) begin
    rvx_pkg::out_item_t want;
    if (rst_n && out_pop && !out_empty) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected beat next_pc", out_item.next_pc, 0);
      end else begin
        want = expected_results.pop_front();
        if (out_item.next_pc !== want.next_pc)
          report_mismatch("next_pc", out_item.next_pc, want.next_pc);
        if (out_item.mem_op !== want.mem_op)
          report_mismatch("mem_op", out_item.mem_op, want.mem_op);
        if (out_item.mem_addr !== want.mem_addr)
          report_mismatch("mem_addr", out_item.mem_addr, want.mem_addr);
        if (out_item.mem_size !== want.mem_size)
          report_mismatch("mem_size", out_item.mem_size, want.mem_size);
        if (out_item.mem_wdata !== want.mem_wdata)
          report_mismatch("mem_wdata", out_item.mem_wdata, want.mem_wdata);
        if (out_item.wb_valid !== want.wb_valid)
          report_mismatch("wb_valid", out_item.wb_valid, want.wb_valid);
        if (out_item.wb_reg !== want.wb_reg)
          report_mismatch("wb_reg", out_item.wb_reg, want.wb_reg);
        if (out_item.wb_data !== want.wb_data)
          report_mismatch("wb_data", out_item.wb_data, want.wb_data);
        if (out_item.status !== want.status)
          report_mismatch("status", out_item.status, want.status);
        if (out_item.trap_value !== want.trap_value)
          report_mismatch("trap_value", out_item.trap_value, want.trap_value);
      end
    end
  end

  // ---------------------------------------------------------------- end of run
  initial begin : finish_run
    cycle_count = 0;
    while (!(feeding_done && expected_results.size() == 0) && cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Some tests failed");
    end else begin
      repeat (60) @(posedge clk);  // catch stray beats after the last divide
      if (error_count == 0) begin
        $display("All tests passed");
      end else begin
        $display("Some tests failed");
      end
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/rvx_pkg.sv
src/rvx_front.sv
src/rvx_div.sv
src/rvx_back.sv
src/rv32im_decode_execute_top.sv
src/rvx_checker.sv
tb/sv/rv32im_decode_execute_top_test.sv
